// ===== rtl/tagged_refcount_slot_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Tagged refcount slot allocator assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TAGGED_REFCOUNT_SLOT_ALLOCATOR_MACROS_SVH
`define TAGGED_REFCOUNT_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TRSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TRSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/trsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Tagged refcount slot allocator package
// Table sizes, derived widths and the function and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package trsa_pkg;

  // Table geometry.
  localparam int NUM_SLOTS = 31;
  localparam int KEY_WIDTH = 32;

  // Width of a slot address, and of a scan counter that can hold NUM_SLOTS.
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

  // Reference count range.
  localparam int          REFS_W  = 8;
  localparam logic [7:0]  REF_MAX = 8'hFF;

  // Request function codes.
  localparam logic FUNC_ACQUIRE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_RANGE  = 3'd2,
    ST_UNUSED = 3'd3,
    ST_SAT    = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/tagged_refcount_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// Tagged refcount slot allocator
// Reference-counted slot table with optional tag keys and one compare unit.
// ----------------------------------------------------------------------------
// Usage: a request is taken on a rising edge with start high and busy low.
// func selects acquire or release; has_tag and tag_key qualify an acquire,
// slot_index names the slot of a release. Each request gives exactly one
// result, shown for one cycle with done high: status, slot_id, released and
// ref_count. The receiver cannot stall; the result must be taken when shown.
// An acquire walks the slot table one entry per cycle through a single key
// compare and count adder, looking for a live matching key and the lowest
// free slot. A tagged acquire scans all NUM_SLOTS entries and then enters
// the claim state unless a match ends it early; an untagged acquire stops
// at the first free slot. A release is answered from the S_REL state alone.
// busy is high from the cycle after acceptance until done, and a new request
// can be taken in the done cycle.
// Reset clears all counts and tag-valid bits at once; no sweep is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_refcount_slot_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func,
  input  wire logic        has_tag,
  input  wire logic [31:0] tag_key,
  input  wire logic [5:0]  slot_index,
  output logic             done,
  output logic [2:0]       status,
  output logic [5:0]       slot_id,
  output logic             released,
  output logic [7:0]       ref_count
);

  localparam int NS  = trsa_pkg::NUM_SLOTS;
  localparam int KW  = trsa_pkg::KEY_WIDTH;
  localparam int SW  = trsa_pkg::SLOT_W;
  localparam int CW  = trsa_pkg::CNT_W;
  localparam int RW  = trsa_pkg::REFS_W;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_CLAIM = 4'b0100,
    S_REL   = 4'b1000
  } state_t;

  state_t state, state_next;

  // Slot table.
  logic [RW-1:0] refs     [NS];
  logic          tag_vld  [NS];
  logic [KW-1:0] keys     [NS];

  // Captured request.
  logic          req_has_tag;
  logic [KW-1:0] key;
  logic [5:0]    idx;

  // Scan state.
  logic [CW-1:0] cnt, cnt_next;
  logic          free_found, free_found_next;
  logic [SW-1:0] free_idx, free_idx_next;

  // Result registers.
  logic                done_next;
  trsa_pkg::status_t   status_q, status_next;
  logic [5:0]          slot_id_next;
  logic                released_next;
  logic [RW-1:0]       ref_count_next;

  // Table access.
  logic [SW-1:0] rd_addr;
  logic [RW-1:0] rd_refs;
  logic          rd_tv;
  logic [KW-1:0] rd_key;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [RW-1:0] wr_refs;
  logic          wr_tv;
  logic [KW-1:0] wr_key;

  // Shared unit outputs.
  logic [RW-1:0] incdec;
  logic          hit;
  logic          is_free;
  logic          last;
  logic          out_of_range;
  logic          accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // One table port: the scan counter during acquire, the request index on release.
  assign rd_addr = (state == S_REL) ? idx[SW-1:0] : cnt[SW-1:0];
  assign rd_refs = refs[rd_addr];
  assign rd_tv   = tag_vld[rd_addr];
  assign rd_key  = keys[rd_addr];

  // Shared compare and count adder.
  assign incdec       = rd_refs + ((state == S_REL) ? {RW{1'b1}} : RW'(1));
  assign hit          = req_has_tag && rd_tv && (rd_key == key);
  assign is_free      = (rd_refs == '0);
  assign last         = (cnt == CW'(NS - 1));
  assign out_of_range = ({1'b0, idx} >= 7'(NS));

  // Sequencer and table write control.
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    done_next       = 1'b0;
    status_next     = status_q;
    slot_id_next    = slot_id;
    released_next   = released;
    ref_count_next  = ref_count;
    wr_en           = 1'b0;
    wr_addr         = rd_addr;
    wr_refs         = '0;
    wr_tv           = 1'b0;
    wr_key          = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cnt_next        = '0;
          free_found_next = 1'b0;
          free_idx_next   = '0;
          state_next      = (func == trsa_pkg::FUNC_RELEASE) ? S_REL : S_SCAN;
        end
      end

      S_SCAN: begin
        if (hit) begin
          // A live slot with the same key takes the reference.
          done_next      = 1'b1;
          slot_id_next   = 6'(rd_addr);
          released_next  = 1'b0;
          state_next     = S_IDLE;
          if (rd_refs == trsa_pkg::REF_MAX) begin
            status_next    = trsa_pkg::ST_SAT;
            ref_count_next = trsa_pkg::REF_MAX;
          end else begin
            status_next    = trsa_pkg::ST_OK;
            ref_count_next = incdec;
            wr_en          = 1'b1;
            wr_refs        = incdec;
            wr_tv          = rd_tv;
            wr_key         = rd_key;
          end
        end else begin
          // Remember the lowest free slot; untagged requests need no more.
          if (is_free && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = rd_addr;
          end
          if (last || (!req_has_tag && is_free)) begin
            state_next = S_CLAIM;
          end else begin
            cnt_next = cnt + CW'(1);
          end
        end
      end

      S_CLAIM: begin
        done_next     = 1'b1;
        released_next = 1'b0;
        state_next    = S_IDLE;
        if (free_found) begin
          status_next    = trsa_pkg::ST_OK;
          slot_id_next   = 6'(free_idx);
          ref_count_next = RW'(1);
          wr_en          = 1'b1;
          wr_addr        = free_idx;
          wr_refs        = RW'(1);
          wr_tv          = req_has_tag;
          wr_key         = req_has_tag ? key : '0;
        end else begin
          status_next    = trsa_pkg::ST_FULL;
          slot_id_next   = '0;
          ref_count_next = '0;
        end
      end

      S_REL: begin
        done_next    = 1'b1;
        slot_id_next = idx;
        state_next   = S_IDLE;
        if (out_of_range) begin
          status_next    = trsa_pkg::ST_RANGE;
          released_next  = 1'b0;
          ref_count_next = '0;
        end else if (is_free) begin
          status_next    = trsa_pkg::ST_UNUSED;
          released_next  = 1'b0;
          ref_count_next = '0;
        end else begin
          // Drop one reference; the last one frees the slot and its key.
          status_next    = trsa_pkg::ST_OK;
          released_next  = (incdec == '0);
          ref_count_next = incdec;
          wr_en          = 1'b1;
          wr_refs        = incdec;
          wr_tv          = (incdec == '0) ? 1'b0 : rd_tv;
          wr_key         = (incdec == '0) ? '0 : rd_key;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state, counts and tag-valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      cnt        <= '0;
      free_found <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        refs[i]    <= '0;
        tag_vld[i] <= 1'b0;
      end
    end else begin
      state      <= state_next;
      done       <= done_next;
      cnt        <= cnt_next;
      free_found <= free_found_next;
      if (wr_en) begin
        refs[wr_addr]    <= wr_refs;
        tag_vld[wr_addr] <= wr_tv;
      end
    end
  end

  // Keys are not reset; a key is only compared behind a set tag-valid bit.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_addr] <= wr_key;
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_has_tag <= has_tag;
      key         <= KW'(tag_key);
      idx         <= slot_index;
    end
    free_idx  <= free_idx_next;
    status_q  <= status_next;
    slot_id   <= slot_id_next;
    released  <= released_next;
    ref_count <= ref_count_next;
  end

  assign status = status_q;

  // Checks.
`include "tagged_refcount_slot_allocator_macros.svh"

  `TRSA_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted request did not start work")
  `TRSA_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result shown while still busy")
  `TRSA_ASSERT_NOW(a_full_zero, clk, rst, done && (status_q == trsa_pkg::ST_FULL),
    (slot_id == '0) && (ref_count == '0) && !released, "full result carries nonzero fields")
  `TRSA_ASSERT_NOW(a_rel_last, clk, rst, done && released,
    (ref_count == '0) && (status_q == trsa_pkg::ST_OK), "release flag with live count")

endmodule

`default_nettype wire

// ===== sim/tb_tagged_refcount_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// Tagged refcount slot allocator testbench
// Sends acquire and release requests through the start/busy handshake. A
// scoreboard keeps its own copy of the slot table, predicts each result and
// checks the done-strobed results in request order. Directed cases come
// first, then a full-table pass, a count saturation pass and random traffic.
// ----------------------------------------------------------------------------
module tb_tagged_refcount_slot_allocator;
  import trsa_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int TAIL_CYCLES   = 40;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int NUM_POOL_KEYS = 6;

  typedef struct packed {
    status_t    status;
    logic [5:0] slot_id;
    logic       released;
    logic [7:0] ref_count;
  } alloc_result_t;

  // Scoreboard: private slot table, prediction per request, in-order checking.
  class alloc_scoreboard;
    logic [REFS_W-1:0]    refs [NUM_SLOTS];
    logic                 tag_live [NUM_SLOTS];
    logic [KEY_WIDTH-1:0] keys [NUM_SLOTS];
    alloc_result_t        pending_results [$];
    int                   mismatches;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        refs[i]     = '0;
        tag_live[i] = 1'b0;
        keys[i]     = '0;
      end
      mismatches = 0;
    endfunction

    // Applies one request to the table copy and returns the result it gives.
    function alloc_result_t predict_slot_op(logic op, logic with_tag, logic [31:0] key_in,
                                            logic [5:0] idx);
      logic [KEY_WIDTH-1:0] key;
      alloc_result_t r;
      key = key_in[KEY_WIDTH-1:0];
      r = '0;
      if (op == FUNC_ACQUIRE) begin
        // A live tagged slot with the same key takes the reference.
        if (with_tag) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tag_live[i] && keys[i] == key) begin
              r.slot_id = 6'(i);
              if (refs[i] == REF_MAX) begin
                r.status    = ST_SAT;
                r.ref_count = REF_MAX;
              end else begin
                refs[i]     = refs[i] + 1'b1;
                r.status    = ST_OK;
                r.ref_count = refs[i];
              end
              return r;
            end
          end
        end
        // Otherwise the lowest free slot is claimed.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (refs[i] == 0) begin
            refs[i]     = REFS_W'(1);
            tag_live[i] = with_tag;
            keys[i]     = with_tag ? key : '0;
            r.status    = ST_OK;
            r.slot_id   = 6'(i);
            r.ref_count = 8'd1;
            return r;
          end
        end
        r.status = ST_FULL;
        return r;
      end
      r.slot_id = idx;
      if (idx >= NUM_SLOTS) begin
        r.status = ST_RANGE;
        return r;
      end
      if (refs[idx] == 0) begin
        r.status = ST_UNUSED;
        return r;
      end
      refs[idx] = refs[idx] - 1'b1;
      r.status  = ST_OK;
      if (refs[idx] == 0) begin
        tag_live[idx] = 1'b0;
        keys[idx]     = '0;
        r.released    = 1'b1;
      end else begin
        r.ref_count = refs[idx];
      end
      return r;
    endfunction

    function void note_request(logic op, logic with_tag, logic [31:0] key, logic [5:0] idx);
      pending_results.push_back(predict_slot_op(op, with_tag, key, idx));
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Picks a slot that currently holds references, or -1 if none does.
    function int random_live_slot();
      int live [$];
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (refs[i] != 0) live.push_back(i);
      end
      if (live.size() == 0) return -1;
      return live[$urandom_range(live.size() - 1)];
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(status_t st, logic [5:0] id, logic rel, logic [7:0] cnt);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result status %0d slot %0d with no request outstanding",
                                  st, id));
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status got %0d want %0d (slot %0d)", st, want.status,
                                  want.slot_id));
      if (id !== want.slot_id)
        report_mismatch($sformatf("slot_id got %0d want %0d", id, want.slot_id));
      if (rel !== want.released)
        report_mismatch($sformatf("released got %0b want %0b (slot %0d)", rel, want.released,
                                  want.slot_id));
      if (cnt !== want.ref_count)
        report_mismatch($sformatf("ref_count got %0d want %0d (slot %0d)", cnt,
                                  want.ref_count, want.slot_id));
    endtask

    task flag_unanswered();
      if (pending_results.size() != 0)
        report_mismatch($sformatf("%0d requests never answered", pending_results.size()));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        start      = 1'b0;
  logic        func       = FUNC_ACQUIRE;
  logic        has_tag    = 1'b0;
  logic [31:0] tag_key    = '0;
  logic [5:0]  slot_index = '0;
  logic        busy;
  logic        done;
  logic [2:0]  status;
  logic [5:0]  slot_id;
  logic        released;
  logic [7:0]  ref_count;

  alloc_scoreboard sb = new();
  int quiet_cycles = 0;

  tagged_refcount_slot_allocator u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .has_tag    (has_tag),
    .tag_key    (tag_key),
    .slot_index (slot_index),
    .done       (done),
    .status     (status),
    .slot_id    (slot_id),
    .released   (released),
    .ref_count  (ref_count)
  );

  always #10 clk = ~clk;

  // Results are taken at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status_t'(status), slot_id, released, ref_count);
  end

  // Count cycles in which neither a request nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("** tagged_refcount_slot_allocator: FAILED **");
    $finish;
  end

  // Holds one request on the ports until an edge with busy low takes it.
  task automatic send_request(logic op, logic with_tag, logic [31:0] key, logic [5:0] idx);
    start      <= 1'b1;
    func       <= op;
    has_tag    <= with_tag;
    tag_key    <= key;
    slot_index <= idx;
    do @(posedge clk); while (busy);
    sb.note_request(op, with_tag, key, idx);
  endtask

  // Sender gap: mostly short, sometimes long enough to span a whole scan.
  task automatic maybe_idle(bit allowed);
    int gap;
    if (!allowed || $urandom_range(99) >= 19) return;
    gap = ($urandom_range(7) == 0) ? $urandom_range(34, 4) : $urandom_range(3, 1);
    start      <= 1'b0;
    func       <= 1'($urandom);
    has_tag    <= 1'($urandom);
    tag_key    <= $urandom;
    slot_index <= 6'($urandom);
    repeat (gap) @(posedge clk);
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic release_all();
    int victim;
    victim = sb.random_live_slot();
    while (victim >= 0) begin
      send_request(FUNC_RELEASE, 1'($urandom), $urandom, 6'(victim));
      maybe_idle(1'b1);
      victim = sb.random_live_slot();
    end
  endtask

  initial begin
    logic [31:0] key_pool [NUM_POOL_KEYS];
    logic [31:0] hot_key;
    logic [5:0]  idx;
    int          fill_bias;
    int          roll;
    int          kind;
    int          victim;
    bit          idling_on;

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < NUM_POOL_KEYS; i++) key_pool[i] = $urandom;
    fill_bias = 50;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: error releases, untagged versus tagged key zero, key match,
    // last reference dropped and slot reuse.
    send_request(FUNC_RELEASE, 1'b0, 32'h0, 6'd0);
    send_request(FUNC_RELEASE, 1'b0, 32'h0, 6'(NUM_SLOTS));
    send_request(FUNC_RELEASE, 1'b1, 32'hFFFF_FFFF, 6'd63);
    send_request(FUNC_ACQUIRE, 1'b0, 32'hAAAA_AAAA, 6'd63);
    send_request(FUNC_ACQUIRE, 1'b1, 32'h0, 6'd0);
    send_request(FUNC_ACQUIRE, 1'b1, 32'h0, 6'd0);
    send_request(FUNC_ACQUIRE, 1'b1, 32'hFFFF_FFFF, 6'd0);
    send_request(FUNC_ACQUIRE, 1'b1, 32'hFFFF_FFFF, 6'd0);
    send_request(FUNC_RELEASE, 1'b0, 32'h0, 6'd0);
    send_request(FUNC_ACQUIRE, 1'b1, 32'h5A5A_5A5A, 6'd0);
    send_request(FUNC_RELEASE, 1'b0, 32'h0, 6'd1);
    send_request(FUNC_RELEASE, 1'b0, 32'h0, 6'd1);
    send_request(FUNC_RELEASE, 1'b0, 32'h0, 6'd1);
    send_request(FUNC_ACQUIRE, 1'b1, 32'h0, 6'd0);
    send_request(FUNC_RELEASE, 1'b0, 32'h0, 6'(NUM_SLOTS - 1));
    send_request(FUNC_RELEASE, 1'b1, 32'h1234_5678, 6'd2);
    send_request(FUNC_ACQUIRE, 1'b0, 32'h0, 6'd0);
    send_request(FUNC_ACQUIRE, 1'b1, 32'hFFFF_FFFF, 6'd0);
    drain_results();

    // Fill the whole table, run into the full status, then empty it again.
    for (int n = 0; n < NUM_SLOTS + 3; n++) begin
      send_request(FUNC_ACQUIRE, 1'($urandom), $urandom, 6'($urandom));
      maybe_idle(1'b1);
    end
    send_request(FUNC_ACQUIRE, 1'b1, 32'hFFFF_FFFF, 6'd0);
    release_all();

    // One key acquired past the count ceiling, then released down to zero.
    hot_key = $urandom;
    for (int n = 0; n < REF_MAX + 3; n++) begin
      send_request(FUNC_ACQUIRE, 1'b1, hot_key, 6'($urandom));
      maybe_idle(1'b1);
    end
    release_all();
    send_request(FUNC_RELEASE, 1'b0, $urandom, 6'd0);

    // Random traffic, alternating between filling and emptying the table.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) fill_bias = ((n / 64) % 2 == 0) ? 70 : 35;
      idling_on = !(n >= 400 && n < 700);
      if (n == 800) drain_results();
      roll = $urandom_range(99);
      kind = $urandom_range(99);
      if (roll < fill_bias) begin
        if (kind < 55)
          send_request(FUNC_ACQUIRE, 1'b1, key_pool[$urandom_range(NUM_POOL_KEYS - 1)],
                       6'($urandom));
        else if (kind < 75)
          send_request(FUNC_ACQUIRE, 1'b1, $urandom, 6'($urandom));
        else
          send_request(FUNC_ACQUIRE, 1'b0, $urandom, 6'($urandom));
      end else begin
        victim = sb.random_live_slot();
        if (kind < 85 && victim >= 0) idx = 6'(victim);
        else if (kind < 93) idx = 6'($urandom_range(NUM_SLOTS - 1));
        else idx = 6'($urandom_range(63));
        send_request(FUNC_RELEASE, 1'($urandom), $urandom, idx);
      end
      maybe_idle(idling_on);
    end

    // Wind down: wait for the last results, then a short quiet tail.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.flag_unanswered();
    if (sb.mismatches == 0)
      $display("** tagged_refcount_slot_allocator: PASSED **");
    else
      $display("** tagged_refcount_slot_allocator: FAILED **");
    $finish;
  end

endmodule
